### rtl/core/mgce_pkg.sv
// ----------------------------------------------------------------------------
// mgce_pkg: shared types and constants for the glyph colour expander
// register map, queue entry and result formats used by the front, back and top of the core
// ----------------------------------------------------------------------------
`default_nettype none

package mgce_pkg;

  localparam int MAX_DIM_DEF    = 1024;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int ROW_BITS       = 8;   // rows carried by one glyph byte
  localparam int ROW_IDX_W      = 3;
  localparam int PAGE_W         = 7;
  localparam int DIM_W          = 11;
  localparam int ORG_W          = 10;
  localparam int ADDR_W         = 20;
  localparam int COLOUR_W       = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int MID_DEPTH      = 4;
  localparam int OUT_DEPTH_DEF  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB_WIDTH     = 3'd0,
    REG_FB_HEIGHT    = 3'd1,
    REG_ORIGIN_X     = 3'd2,
    REG_ORIGIN_Y     = 3'd3,
    REG_GLYPH_WIDTH  = 3'd4,
    REG_GLYPH_HEIGHT = 3'd5,
    REG_FG_COLOUR    = 3'd6,
    REG_BG_COLOUR    = 3'd7
  } mgce_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]    fb_width;
    logic [DIM_W-1:0]    fb_height;
    logic [ORG_W-1:0]    origin_x;
    logic [ORG_W-1:0]    origin_y;
    logic [DIM_W-1:0]    glyph_width;
    logic [DIM_W-1:0]    glyph_height;
    logic [COLOUR_W-1:0] fg_colour;
    logic [COLOUR_W-1:0] bg_colour;
  } mgce_cfg_t;

  // one classified glyph byte waiting for expansion
  typedef struct packed {
    logic [ROW_BITS-1:0] byte_bits;
    logic [ROW_BITS-1:0] mask;      // bits that give a write
    logic [DIM_W-1:0]    x;         // absolute column, always below fb_width
    logic [DIM_W-1:0]    y_base;    // absolute row of bit 0
  } mgce_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   pixel_address;
    logic [COLOUR_W-1:0] pixel_colour;
    logic                bit_was_set;
    logic                last;
  } mgce_result_t;

endpackage

`default_nettype wire

### rtl/core/mgce_fifo.sv
// ----------------------------------------------------------------------------
// mgce_fifo: small flop-based queue
// head shown combinationally, occupancy count exported for credit checks
// ----------------------------------------------------------------------------
`default_nettype none

module mgce_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mgce_front.sv
// ----------------------------------------------------------------------------
// mgce_front: glyph byte intake and classification
// tracks column and page, builds the per-bit write mask, queues useful bytes
// ----------------------------------------------------------------------------
`default_nettype none

module mgce_front #(
  parameter int MAX_DIM = mgce_pkg::MAX_DIM_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mgce_pkg::mgce_cfg_t     cfg,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [7:0]              in_glyph_byte,
  input  logic                    in_start_req,
  output logic                    item_push,
  output mgce_pkg::mgce_item_t    item,
  input  logic                    item_full
);

  import mgce_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int GW_W  = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
  localparam int XW    = (CNT_W > ORG_W) ? CNT_W + 1 : ORG_W + 1;
  localparam int ROW_W = PAGE_W + ROW_IDX_W;

  logic [CNT_W-1:0]    column_r, column_nxt, col_cur;
  logic [PAGE_W-1:0]   page_r, page_nxt, page_cur;
  logic [XW-1:0]       x_full;
  logic                x_ok, accept;
  logic [ROW_W-1:0]    row_a [ROW_BITS];
  logic [DIM_W-1:0]    y_a   [ROW_BITS];
  logic [ROW_BITS-1:0] mask;
  logic [GW_W-1:0]     gw, col_inc;

  assign in_full = item_full;
  assign accept  = in_push && !item_full;

  // a start request restarts the walk before this byte is placed
  assign col_cur  = in_start_req ? '0 : column_r;
  assign page_cur = in_start_req ? '0 : page_r;

  assign x_full = XW'(cfg.origin_x) + XW'(col_cur);
  assign x_ok   = (x_full < XW'(cfg.fb_width));

  always_comb begin
    for (int n = 0; n < ROW_BITS; n++) begin
      row_a[n] = {page_cur, ROW_IDX_W'(n)};
      y_a[n]   = DIM_W'(cfg.origin_y) + DIM_W'(row_a[n]);
      mask[n]  = x_ok && (DIM_W'(row_a[n]) < cfg.glyph_height) && (y_a[n] < cfg.fb_height);
    end
  end

  // glyph width clamps to the largest supported, zero wraps every byte
  assign gw = (GW_W'(cfg.glyph_width) > GW_W'(MAX_DIM)) ? GW_W'(MAX_DIM)
                                                         : GW_W'(cfg.glyph_width);
  assign col_inc = GW_W'(col_cur) + GW_W'(1);

  always_comb begin
    if (col_inc >= gw) begin
      column_nxt = '0;
      page_nxt   = page_cur + PAGE_W'(1);
    end else begin
      column_nxt = col_inc[CNT_W-1:0];
      page_nxt   = page_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      page_r   <= '0;
    end else if (accept) begin
      column_r <= column_nxt;
      page_r   <= page_nxt;
    end
  end

  // fully clipped bytes never reach the queue
  assign item_push      = accept && (|mask);
  assign item.byte_bits = in_glyph_byte;
  assign item.mask      = mask;
  assign item.x         = x_full[DIM_W-1:0];
  assign item.y_base    = y_a[0];

endmodule

`default_nettype wire

### rtl/core/mgce_back.sv
// ----------------------------------------------------------------------------
// mgce_back: pixel write generator
// issues one write per cycle from the queued byte while result slots are free, then address multiply
// ----------------------------------------------------------------------------
`default_nettype none

module mgce_back #(
  parameter int OUT_DEPTH = mgce_pkg::OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mgce_pkg::mgce_cfg_t            cfg,
  input  logic                           item_empty,
  input  mgce_pkg::mgce_item_t           item,
  output logic                           item_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           res_push,
  output mgce_pkg::mgce_result_t         res
);

  import mgce_pkg::*;

  localparam int OC_W   = $clog2(OUT_DEPTH+1);
  localparam int SUM_W  = OC_W + 2;
  localparam int PROD_W = 2 * DIM_W;

  logic [ROW_BITS-1:0]  done_r, done_nxt, remaining, pick;
  logic [ROW_IDX_W-1:0] bit_idx;
  logic [SUM_W-1:0]     committed;
  logic                 space, issue, pick_last, pick_set;
  logic [DIM_W-1:0]     y;
  logic [PROD_W-1:0]    prod;

  logic                 s1_v_r, s1_set_r, s1_last_r;
  logic [DIM_W-1:0]     s1_y_r, s1_x_r;
  logic [COLOUR_W-1:0]  s1_colour_r;
  logic                 s2_v_r, s2_set_r, s2_last_r;
  logic [ADDR_W-1:0]    s2_prod_r;
  logic [DIM_W-1:0]     s2_x_r;
  logic [COLOUR_W-1:0]  s2_colour_r;

  // reserve output slots for everything still in flight
  assign committed = SUM_W'(out_count) + SUM_W'(s1_v_r) + SUM_W'(s2_v_r);
  assign space     = (committed < SUM_W'(OUT_DEPTH));
  assign issue     = !item_empty && space;

  assign remaining = item.mask & ~done_r;
  assign pick      = remaining & (~remaining + ROW_BITS'(1));
  assign pick_last = ((remaining & ~pick) == '0);
  assign pick_set  = |(item.byte_bits & pick);
  assign item_pop  = issue && pick_last;

  always_comb begin
    bit_idx = '0;
    for (int n = 0; n < ROW_BITS; n++) begin
      if (pick[n]) begin
        bit_idx = ROW_IDX_W'(n);
      end
    end
  end

  assign y = item.y_base + DIM_W'(bit_idx);

  always_comb begin
    done_nxt = done_r;
    if (issue) begin
      done_nxt = pick_last ? '0 : (done_r | pick);
    end
  end

  assign prod = PROD_W'(s1_y_r) * PROD_W'(cfg.fb_width);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_y_r      <= y;
    s1_x_r      <= item.x;
    s1_colour_r <= pick_set ? cfg.fg_colour : cfg.bg_colour;
    s1_set_r    <= pick_set;
    s1_last_r   <= pick_last;
    s2_prod_r   <= prod[ADDR_W-1:0];
    s2_x_r      <= s1_x_r;
    s2_colour_r <= s1_colour_r;
    s2_set_r    <= s1_set_r;
    s2_last_r   <= s1_last_r;
  end

  assign res_push          = s2_v_r;
  assign res.pixel_address = s2_prod_r + ADDR_W'(s2_x_r);
  assign res.pixel_colour  = s2_colour_r;
  assign res.bit_was_set   = s2_set_r;
  assign res.last          = s2_last_r;

endmodule

`default_nettype wire

### rtl/core/mono_glyph_colour_expand_core.sv
// ----------------------------------------------------------------------------
// mono_glyph_colour_expand_core: monochrome glyph to framebuffer writes
// page-ordered 1-bit glyph bytes in, clipped colour pixel writes out
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          request contents
//  -------  ---------  -----------------  ---------------------------------------
//  in_      input      in_push / in_full  glyph byte, start of glyph flag
//  out_     output     out_empty/out_pop  address, colour, set bit, last of byte
//  cfg_     input      cfg_valid/ready    register index, write data
//
//  one pixel write leaves per cycle through the single result port while the consumer
//  pops and writes are pending; a byte yields 0 to 8 writes, eight when unclipped
//  a byte that yields no write is absorbed at the input and never queued
//  writes reach the ports through the mid queue, the s1 and s2 registers and the result queue
//  reset restores the register defaults, clears the column and page walk and
//  empties both queues; either side may stall without losing a request
//
`default_nettype none

module mono_glyph_colour_expand_core #(
  parameter int MAX_DIM    = mgce_pkg::MAX_DIM_DEF,
  parameter int PIXEL_BITS = mgce_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // glyph byte intake
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [7:0]                        in_glyph_byte,
  input  logic                              in_start_req,
  // pixel writes
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [mgce_pkg::ADDR_W-1:0]       out_pixel_address,
  output logic [mgce_pkg::COLOUR_W-1:0]     out_pixel_colour,
  output logic                              out_bit_was_set,
  output logic                              out_last,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mgce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mgce_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import mgce_pkg::*;

  localparam int OUT_DEPTH = OUT_DEPTH_DEF;
  localparam int OC_W      = $clog2(OUT_DEPTH+1);
  localparam int MC_W      = $clog2(MID_DEPTH+1);
  localparam int ITEM_W    = $bits(mgce_item_t);
  localparam int RES_W     = $bits(mgce_result_t);
  // colours keep only the pixel depth of the framebuffer
  localparam logic [COLOUR_W-1:0] CLR_MASK =
    (PIXEL_BITS >= COLOUR_W) ? {COLOUR_W{1'b1}} : COLOUR_W'((1 << PIXEL_BITS) - 1);

  mgce_cfg_t    cfg_r, cfg_nxt;
  logic         cfg_we;

  mgce_item_t   mid_wdata, mid_rdata;
  logic         mid_push, mid_full, mid_pop, mid_empty;
  logic [MC_W-1:0] mid_count;

  mgce_result_t res_wdata, res_rdata;
  logic         res_push, res_full;
  logic [OC_W-1:0] res_count;

  // ---------------------------------------------------------------------------
  // register file, always ready and unguarded: the user must write it only while the core is idle
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FB_WIDTH:     cfg_nxt.fb_width     = cfg_data[DIM_W-1:0];
        REG_FB_HEIGHT:    cfg_nxt.fb_height    = cfg_data[DIM_W-1:0];
        REG_ORIGIN_X:     cfg_nxt.origin_x     = cfg_data[ORG_W-1:0];
        REG_ORIGIN_Y:     cfg_nxt.origin_y     = cfg_data[ORG_W-1:0];
        REG_GLYPH_WIDTH:  cfg_nxt.glyph_width  = cfg_data[DIM_W-1:0];
        REG_GLYPH_HEIGHT: cfg_nxt.glyph_height = cfg_data[DIM_W-1:0];
        REG_FG_COLOUR:    cfg_nxt.fg_colour    = cfg_data[COLOUR_W-1:0] & CLR_MASK;
        REG_BG_COLOUR:    cfg_nxt.bg_colour    = cfg_data[COLOUR_W-1:0] & CLR_MASK;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fb_width     <= DIM_W'(320);
      cfg_r.fb_height    <= DIM_W'(240);
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.glyph_width  <= DIM_W'(8);
      cfg_r.glyph_height <= DIM_W'(8);
      cfg_r.fg_colour    <= CLR_MASK;
      cfg_r.bg_colour    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // front: column/page walk and clip mask, drops fully clipped bytes
  // ---------------------------------------------------------------------------
  mgce_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_glyph_byte (in_glyph_byte),
    .in_start_req  (in_start_req),
    .item_push     (mid_push),
    .item          (mid_wdata),
    .item_full     (mid_full)
  );

  // short queue between classification and expansion
  mgce_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  // ---------------------------------------------------------------------------
  // back: one write per cycle while result slots are free, lowest row first, address multiply pipeline
  // ---------------------------------------------------------------------------
  mgce_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_empty (mid_empty),
    .item       (mid_rdata),
    .item_pop   (mid_pop),
    .out_count  (res_count),
    .res_push   (res_push),
    .res        (res_wdata)
  );

  // result queue decouples the write port from downstream stalls
  mgce_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty),
    .count (res_count)
  );

  assign out_pixel_address = res_rdata.pixel_address;
  assign out_pixel_colour  = res_rdata.pixel_colour;
  assign out_bit_was_set   = res_rdata.bit_was_set;
  assign out_last          = res_rdata.last;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // slot reservation in the back end must never let a write hit a full queue
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("pixel write pushed into full result queue");

  // front only pushes when its input handshake saw room
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    mid_push |-> !mid_full)
    else $error("classified byte pushed into full queue");

  // back end retires a byte only while one is queued
  a_mid_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("byte retired from empty queue");

  // a queued byte always carries at least one write
  a_mid_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
    mid_push |-> (mid_wdata.mask != '0))
    else $error("byte without writes entered the queue");

  // a write is pushed through the s1 and s2 registers only after the back end picked a bit from a queued byte
  a_pipe_timing: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> ($past(mid_count, 2) != '0))
    else $error("pixel write without a queued byte");

endmodule

`default_nettype wire
